@@ hdl/sync_framed_packet_receiver_assert.svh @@
// Assertion macros used by the receiver datapath (sfpr_dp).
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef SYNC_FRAMED_PACKET_RECEIVER_ASSERT_SVH
`define SYNC_FRAMED_PACKET_RECEIVER_ASSERT_SVH

// Same-cycle implication
`define SFPR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfpr: same-cycle check failed");

// Next-cycle implication
`define SFPR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfpr: next-cycle check failed");

`endif

@@ hdl/sfpr_pkg.sv @@
`default_nettype none

package sfpr_pkg;

  // Default payload buffer depth
  localparam int BUFFER_DEPTH_DEF = 64;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_SYNC  = 2'd0,
    CFG_SECOND_SYNC = 2'd1,
    CFG_OWN_ADDR    = 2'd2,
    CFG_REJECT_LOOP = 2'd3
  } cfg_idx_t;

  // Controller states: frame parse phases plus the result drain
  typedef enum logic [3:0] {
    ST_SYNC_A,
    ST_SYNC_B,
    ST_SOURCE,
    ST_DEST,
    ST_LENGTH,
    ST_PAYLOAD,
    ST_CRC_LO,
    ST_CRC_HI,
    ST_TRAIL_B,
    ST_TRAIL_A,
    ST_DRAIN_RD,
    ST_DRAIN_WR
  } phase_t;

  // Input transaction
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       tx_active;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic [7:0]  source_addr;
    logic [6:0]  payload_length;
    logic [5:0]  byte_index;
    logic [7:0]  payload_byte;
    logic        has_byte;
    logic [15:0] frame_crc;
    logic        last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic ld_source;
    logic ld_length;
    logic clr_count;
    logic wr_payload;
    logic ld_crc_lo;
    logic ld_crc_hi;
    logic drain_start;
    logic rd_en;
    logic out_load;
    logic drain_step;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic drop;
    logic sync_a_hit;
    logic sync_b_hit;
    logic dest_hit;
    logic len_over;
    logic len_in_zero;
    logic len_zero;
    logic pay_last;
    logic drain_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ hdl/sync_framed_packet_receiver.sv @@
// Channel  Handshake          Payload
// in_      in_valid/in_stall  sfpr_pkg::in_item_t  (rx_byte, tx_active)
// out_     out_valid/out_stall sfpr_pkg::out_item_t (one per payload byte)
// cfg_     cfg_valid/cfg_ready cfg_index, cfg_data (always ready)
//
// The frame parser takes each received byte as it arrives.
// On a good trailer the payload buffer is drained one result at a time
// (buffer read, then output register load); an empty frame gives one result.
// in_stall is high during the drain; output stalls hold the drain.
// Synchronous active-low reset; the payload buffer is not cleared.
`default_nettype none

module sync_framed_packet_receiver #(
  parameter int BUFFER_DEPTH = sfpr_pkg::BUFFER_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire sfpr_pkg::in_item_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output sfpr_pkg::out_item_t                 out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [sfpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                     cfg_data
);

  sfpr_pkg::cmd_t cmd;
  sfpr_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  // Frame parser and drain sequencer
  sfpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Registers, payload buffer and result register
  sfpr_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ hdl/sfpr_ram.sv @@
`default_nettype none

module sfpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ hdl/sfpr_ctrl.sv @@
`default_nettype none

module sfpr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire sfpr_pkg::sts_t sts,
  output sfpr_pkg::cmd_t     cmd
);

  sfpr_pkg::phase_t state_r, state_nxt;
  logic             step;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfpr_pkg::ST_SYNC_A;
    end else begin
      state_r <= state_nxt;
    end
  end

  // No input while results are being drained
  assign in_stall = (state_r == sfpr_pkg::ST_DRAIN_RD) ||
                    (state_r == sfpr_pkg::ST_DRAIN_WR);

  // A transaction that is not a dropped loopback byte advances the parser
  assign step = in_valid && !in_stall && !sts.drop;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      sfpr_pkg::ST_SYNC_A: begin
        if (step && sts.sync_a_hit) begin
          state_nxt = sfpr_pkg::ST_SYNC_B;
        end
      end
      sfpr_pkg::ST_SYNC_B: begin
        if (step) begin
          state_nxt = sts.sync_b_hit ? sfpr_pkg::ST_SOURCE : sfpr_pkg::ST_SYNC_A;
        end
      end
      sfpr_pkg::ST_SOURCE: begin
        if (step) begin
          cmd.ld_source = 1'b1;
          state_nxt     = sfpr_pkg::ST_DEST;
        end
      end
      sfpr_pkg::ST_DEST: begin
        if (step) begin
          state_nxt = sts.dest_hit ? sfpr_pkg::ST_LENGTH : sfpr_pkg::ST_SYNC_A;
        end
      end
      sfpr_pkg::ST_LENGTH: begin
        if (step) begin
          cmd.clr_count = 1'b1;
          if (sts.len_over) begin
            state_nxt = sfpr_pkg::ST_SYNC_A;
          end else begin
            cmd.ld_length = 1'b1;
            state_nxt     = sts.len_in_zero ? sfpr_pkg::ST_CRC_LO : sfpr_pkg::ST_PAYLOAD;
          end
        end
      end
      sfpr_pkg::ST_PAYLOAD: begin
        if (step) begin
          cmd.wr_payload = 1'b1;
          if (sts.pay_last) begin
            state_nxt = sfpr_pkg::ST_CRC_LO;
          end
        end
      end
      sfpr_pkg::ST_CRC_LO: begin
        if (step) begin
          cmd.ld_crc_lo = 1'b1;
          state_nxt     = sfpr_pkg::ST_CRC_HI;
        end
      end
      sfpr_pkg::ST_CRC_HI: begin
        if (step) begin
          cmd.ld_crc_hi = 1'b1;
          state_nxt     = sfpr_pkg::ST_TRAIL_B;
        end
      end
      sfpr_pkg::ST_TRAIL_B: begin
        if (step) begin
          state_nxt = sts.sync_b_hit ? sfpr_pkg::ST_TRAIL_A : sfpr_pkg::ST_SYNC_A;
        end
      end
      sfpr_pkg::ST_TRAIL_A: begin
        if (step) begin
          if (sts.sync_a_hit) begin
            // Frame complete: an empty frame skips the buffer read
            cmd.drain_start = 1'b1;
            state_nxt = (sts.len_zero) ? sfpr_pkg::ST_DRAIN_WR : sfpr_pkg::ST_DRAIN_RD;
          end else begin
            state_nxt = sfpr_pkg::ST_SYNC_A;
          end
        end
      end
      sfpr_pkg::ST_DRAIN_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = sfpr_pkg::ST_DRAIN_WR;
      end
      sfpr_pkg::ST_DRAIN_WR: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.drain_last) begin
            state_nxt = sfpr_pkg::ST_SYNC_A;
          end else begin
            cmd.drain_step = 1'b1;
            state_nxt      = sfpr_pkg::ST_DRAIN_RD;
          end
        end
      end
      default: begin
        state_nxt = sfpr_pkg::ST_SYNC_A;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/sfpr_dp.sv @@
`default_nettype none

`include "sync_framed_packet_receiver_assert.svh"

module sfpr_dp #(
  parameter int BUFFER_DEPTH = sfpr_pkg::BUFFER_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire sfpr_pkg::in_item_t            in_data,
  input  wire logic                          cfg_we,
  input  wire logic [sfpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                    cfg_data,
  input  wire sfpr_pkg::cmd_t                cmd,
  output sfpr_pkg::sts_t                     sts,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output sfpr_pkg::out_item_t                out_data
);

  localparam int IDX_W = $clog2(BUFFER_DEPTH);
  localparam int LEN_W = $clog2(BUFFER_DEPTH + 1);

  // Configuration registers
  logic [7:0] first_sync_r;
  logic [7:0] second_sync_r;
  logic [7:0] own_addr_r;
  logic       reject_loop_r;

  // Frame fields
  logic [7:0]       source_r;
  logic [LEN_W-1:0] length_r;
  logic [LEN_W-1:0] count_r;
  logic [15:0]      crc_r;
  logic [LEN_W-1:0] drain_idx_r;
  logic             out_valid_r;
  sfpr_pkg::out_item_t out_data_r;

  logic [7:0]     rd_byte;
  logic [LEN_W:0] count_inc;
  logic [LEN_W:0] drain_inc;
  logic           len_zero;
  logic           drain_last;

  // Configuration writes; unknown codes cannot occur with a 2-bit index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_sync_r  <= '0;
      second_sync_r <= '0;
      own_addr_r    <= '0;
      reject_loop_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfpr_pkg::CFG_FIRST_SYNC:  first_sync_r  <= cfg_data;
        sfpr_pkg::CFG_SECOND_SYNC: second_sync_r <= cfg_data;
        sfpr_pkg::CFG_OWN_ADDR:    own_addr_r    <= cfg_data;
        sfpr_pkg::CFG_REJECT_LOOP: reject_loop_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Header, length, payload counter and CRC capture
  always_ff @(posedge clk) begin
    if (cmd.ld_source) begin
      source_r <= in_data.rx_byte;
    end
    if (cmd.ld_length) begin
      length_r <= in_data.rx_byte[LEN_W-1:0];
    end
    if (cmd.clr_count) begin
      count_r <= '0;
    end else if (cmd.wr_payload) begin
      count_r <= count_inc[LEN_W-1:0];
    end
    if (cmd.ld_crc_lo) begin
      crc_r <= {8'h00, in_data.rx_byte};
    end else if (cmd.ld_crc_hi) begin
      crc_r <= {in_data.rx_byte, crc_r[7:0]};
    end
    if (cmd.drain_start) begin
      drain_idx_r <= '0;
    end else if (cmd.drain_step) begin
      drain_idx_r <= drain_inc[LEN_W-1:0];
    end
  end

  // Payload buffer
  sfpr_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (cmd.wr_payload),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (in_data.rx_byte),
    .re    (cmd.rd_en),
    .raddr (drain_idx_r[IDX_W-1:0]),
    .rdata (rd_byte)
  );

  assign count_inc  = {1'b0, count_r} + (LEN_W+1)'(1);
  assign drain_inc  = {1'b0, drain_idx_r} + (LEN_W+1)'(1);
  assign len_zero   = (length_r == '0);
  assign drain_last = len_zero || (drain_inc == {1'b0, length_r});

  // Status to controller
  always_comb begin
    sts.drop        = reject_loop_r && in_data.tx_active;
    sts.sync_a_hit  = (in_data.rx_byte == first_sync_r);
    sts.sync_b_hit  = (in_data.rx_byte == second_sync_r);
    sts.dest_hit    = ((in_data.rx_byte & own_addr_r) == own_addr_r);
    sts.len_over    = ({1'b0, in_data.rx_byte} > 9'(BUFFER_DEPTH));
    sts.len_in_zero = (in_data.rx_byte == 8'h00);
    sts.len_zero    = len_zero;
    sts.pay_last    = (count_inc >= {1'b0, length_r});
    sts.drain_last  = drain_last;
    sts.out_free    = !out_valid_r || !out_stall;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.source_addr    <= source_r;
      out_data_r.payload_length <= 7'(length_r);
      out_data_r.byte_index     <= 6'(drain_idx_r);
      out_data_r.payload_byte   <= len_zero ? 8'h00 : rd_byte;
      out_data_r.has_byte       <= !len_zero;
      out_data_r.frame_crc      <= crc_r;
      out_data_r.last           <= drain_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A pending result is never overwritten
  `SFPR_ASSERT_IMP(a_load_free, cmd.out_load, !out_valid_r || !out_stall)
  // Payload writes stay inside the buffer
  `SFPR_ASSERT_IMP(a_wr_range, cmd.wr_payload, {1'b0, count_r} < (LEN_W+1)'(BUFFER_DEPTH))
  // Drain reads only entries of the current frame
  `SFPR_ASSERT_IMP(a_rd_range, cmd.rd_en, drain_idx_r < length_r)
  // A loaded result is presented next cycle
  `SFPR_ASSERT_NXT(a_load_shows, cmd.out_load, out_valid_r)

endmodule

`default_nettype wire
